// ===== hdl/q4dp_pkg.sv =====
// ----------------------------------------------------------------------------
// q4dp_pkg
// Shared constants, lane control type and IEEE single arithmetic for the
// quantized 4-bit block dot product.
// ----------------------------------------------------------------------------
`default_nettype none

package q4dp_pkg;

  localparam int VECTOR_DEPTH = 16384;
  localparam int BANKS        = 4;
  localparam int BANK_DEPTH   = (VECTOR_DEPTH + BANKS - 1) / BANKS;
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int NBLK         = VECTOR_DEPTH / 32;
  localparam int POS_W        = $clog2(NBLK + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BLOCK = 1'b1;

  // lane step codes, in issue order
  localparam logic [3:0] ST_P01   = 4'd0;
  localparam logic [3:0] ST_P23   = 4'd1;
  localparam logic [3:0] ST_PART0 = 4'd2;
  localparam logic [3:0] ST_P45   = 4'd3;
  localparam logic [3:0] ST_P67   = 4'd4;
  localparam logic [3:0] ST_PART1 = 4'd5;
  localparam logic [3:0] ST_BOTH  = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_ACC   = 4'd8;

  localparam logic [31:0] F32_DEF_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QUIET   = 32'h0040_0000;
  localparam logic [30:0] F32_INF_MAG = 31'h7F80_0000;

  typedef struct packed {
    logic       clr;
    logic       prod_en;
    logic [2:0] prod_idx;
    logic       step_en;
    logic [3:0] step;
  } lane_ctl_t;

  // weight nibble minus 8, as an exact single
  function automatic logic [31:0] nib_to_f32(input logic [3:0] nib);
    logic       neg;
    logic [3:0] mag;
    logic [1:0] p;
    logic [26:0] t;
    logic [31:0] res;
    neg = ~nib[3];
    mag = nib[3] ? {1'b0, nib[2:0]} : (4'd8 - nib);
    p = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (mag[i]) p = 2'(i);
    end
    t = {mag, 23'b0} >> p;
    if (mag == 4'd0) res = 32'd0;
    else res = {neg, 8'(8'd127 + 8'(p)), t[22:0]};
    return res;
  endfunction

  // half bits to single bits, exact
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  f;
    logic [3:0]  p;
    logic [32:0] t;
    logic [31:0] res;
    s = h[15];
    e = h[14:10];
    f = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (f[i]) p = 4'(i);
    end
    t = {f, 23'b0} >> p;
    if (e == 5'd0) begin
      if (f == 10'd0) res = {s, 31'd0};
      else res = {s, 8'(8'd103 + 8'(p)), t[22:0]};
    end else if (e == 5'd31) begin
      res = {s, 8'hFF, f, 13'd0};
    end else begin
      res = {s, 8'(8'd112 + 8'(e)), f, 13'd0};
    end
    return res;
  endfunction

  // single add, round to nearest even
  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf, swap, s_big, s_sml, stk, g, rs, inc;
    logic [8:0]  ea, eb, e_big, e_sml, d, e, shl;
    logic [23:0] ma, mb, m_big, m_sml;
    logic [4:0]  dc, lz;
    logic [53:0] sh;
    logic [26:0] xs;
    logic [27:0] s;
    logic [31:0] res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    swap  = {ea, ma} < {eb, mb};
    e_big = swap ? eb : ea;
    e_sml = swap ? ea : eb;
    m_big = swap ? mb : ma;
    m_sml = swap ? ma : mb;
    s_big = swap ? b[31] : a[31];
    s_sml = swap ? a[31] : b[31];
    d  = e_big - e_sml;
    dc = (d > 9'd28) ? 5'd28 : d[4:0];
    sh = {m_sml, 3'b000, 27'd0} >> dc;
    xs = sh[53:27];
    stk = |sh[26:0];
    xs[0] = xs[0] | stk;
    if (s_big == s_sml) s = {1'b0, m_big, 3'b000} + {1'b0, xs};
    else s = {1'b0, m_big, 3'b000} - {1'b0, xs};
    e = e_big;
    lz = 5'd0;
    shl = 9'd0;
    if (s[27]) begin
      s = {1'b0, s[27:2], s[1] | s[0]};
      e = e + 9'd1;
    end else begin
      for (int i = 0; i < 27; i++) begin
        if (s[i]) lz = 5'(26 - i);
      end
      shl = ({4'd0, lz} < (e - 9'd1)) ? {4'd0, lz} : (e - 9'd1);
      s = s << shl;
      e = e - shl;
    end
    g   = s[2];
    rs  = s[1] | s[0];
    inc = g & (rs | s[3]);
    if (e >= 9'd255) res = {s_big, F32_INF_MAG};
    else res = {s_big, (s[26] ? e[7:0] : 8'd0), s[25:3]} + {31'd0, inc};
    if (s == 28'd0) res = {a[31] & b[31], 31'd0};
    if (a_nan) res = a | F32_QUIET;
    else if (b_nan) res = b | F32_QUIET;
    else if (a_inf && b_inf && (a[31] != b[31])) res = F32_DEF_NAN;
    else if (a_inf) res = a;
    else if (b_inf) res = b;
    return res;
  endfunction

  // single multiply, round to nearest even
  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s, stk, g, st, inc;
    logic [8:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        pr;
    logic [5:0]         lz, rsh;
    logic signed [11:0] e0, e;
    logic [31:0]        res;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    s  = a[31] ^ b[31];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    pr = ma * mb;
    e0 = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 12'sd126;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (pr[i]) lz = 6'(47 - i);
    end
    stk = 1'b0;
    rsh = 6'd0;
    if (e0 - $signed({6'd0, lz}) >= 12'sd1) begin
      pr = pr << lz;
      e  = e0 - $signed({6'd0, lz});
    end else if (e0 >= 12'sd1) begin
      pr = pr << 6'(e0 - 12'sd1);
      e  = 12'sd1;
    end else begin
      rsh = ((12'sd1 - e0) > 12'sd48) ? 6'd48 : 6'(12'sd1 - e0);
      stk = |(pr & ((48'd1 << rsh) - 48'd1));
      pr  = pr >> rsh;
      e   = 12'sd1;
    end
    g   = pr[23];
    st  = (|pr[22:0]) | stk;
    inc = g & (st | pr[24]);
    if (e >= 12'sd255) res = {s, F32_INF_MAG};
    else res = {s, (pr[47] ? e[7:0] : 8'd0), pr[46:24]} + {31'd0, inc};
    if (a_nan) res = a | F32_QUIET;
    else if (b_nan) res = b | F32_QUIET;
    else if ((a_inf && b_zero) || (b_inf && a_zero)) res = F32_DEF_NAN;
    else if (a_inf || b_inf) res = {s, F32_INF_MAG};
    else if (a_zero || b_zero) res = {s, 31'd0};
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/q4dp_if.sv =====
// ----------------------------------------------------------------------------
// q4dp channel interfaces
// Valid/ready channels for input items and row results.
// ----------------------------------------------------------------------------
`default_nettype none

interface q4dp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [13:0] act_index;
  logic [31:0] act_value;
  logic [15:0] block_scale;
  logic [63:0] quant_bytes_lo;
  logic [63:0] quant_bytes_hi;
  logic        row_end;

  modport source (
    output valid, operation, act_index, act_value, block_scale,
           quant_bytes_lo, quant_bytes_hi, row_end,
    input  ready
  );
  modport sink (
    input  valid, operation, act_index, act_value, block_scale,
           quant_bytes_lo, quant_bytes_hi, row_end,
    output ready
  );
endinterface

interface q4dp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_sum;
  logic        column_overflow;

  modport source (output valid, row_sum, column_overflow, input ready);
  modport sink   (input valid, row_sum, column_overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/q4dp_ram.sv =====
// ----------------------------------------------------------------------------
// q4dp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module q4dp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/q4dp_lane.sv =====
// ----------------------------------------------------------------------------
// q4dp_lane
// One summation lane: eight weight products, ordered add tree, scale and
// running lane sum, on one shared adder and one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module q4dp_lane (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire q4dp_pkg::lane_ctl_t  ctl,
  input  wire logic [31:0]          act,
  input  wire logic [31:0]          wbytes,
  input  wire logic [31:0]          scale,
  output logic      [31:0]          sum
);

  logic [31:0] p_r [8];
  logic [31:0] r0_r, r1_r, r2_r, acc_r;
  logic [1:0]  g;
  logic [3:0]  nib;
  logic [31:0] mul_a, mul_b, mul_y, add_a, add_b, add_y;

  assign g   = ctl.prod_idx[1:0];
  assign nib = ctl.prod_idx[2] ? wbytes[8*g+4 +: 4] : wbytes[8*g +: 4];

  always_comb begin
    mul_a = ctl.prod_en ? q4dp_pkg::nib_to_f32(nib) : scale;
    mul_b = ctl.prod_en ? act : r0_r;
    mul_y = q4dp_pkg::f32_mul(mul_a, mul_b);
  end

  always_comb begin
    unique case (ctl.step)
      q4dp_pkg::ST_P01:   begin add_a = p_r[0]; add_b = p_r[1]; end
      q4dp_pkg::ST_P23:   begin add_a = p_r[2]; add_b = p_r[3]; end
      q4dp_pkg::ST_PART0: begin add_a = r0_r;   add_b = r1_r;   end
      q4dp_pkg::ST_P45:   begin add_a = p_r[4]; add_b = p_r[5]; end
      q4dp_pkg::ST_P67:   begin add_a = p_r[6]; add_b = p_r[7]; end
      q4dp_pkg::ST_PART1: begin add_a = r1_r;   add_b = r2_r;   end
      q4dp_pkg::ST_BOTH:  begin add_a = r0_r;   add_b = r1_r;   end
      q4dp_pkg::ST_ACC:   begin add_a = acc_r;  add_b = r0_r;   end
      default:            begin add_a = 32'd0;  add_b = 32'd0;  end
    endcase
    add_y = q4dp_pkg::f32_add(add_a, add_b);
  end

  // products and partial sums
  always_ff @(posedge clk) begin
    if (ctl.prod_en) p_r[ctl.prod_idx] <= mul_y;
    if (ctl.step_en) begin
      unique case (ctl.step)
        q4dp_pkg::ST_P01:   r0_r <= add_y;
        q4dp_pkg::ST_P23:   r1_r <= add_y;
        q4dp_pkg::ST_PART0: r0_r <= add_y;
        q4dp_pkg::ST_P45:   r1_r <= add_y;
        q4dp_pkg::ST_P67:   r2_r <= add_y;
        q4dp_pkg::ST_PART1: r1_r <= add_y;
        q4dp_pkg::ST_BOTH:  r0_r <= add_y;
        q4dp_pkg::ST_SCALE: r0_r <= mul_y;
        default:            ;
      endcase
    end
  end

  // running lane sum, positive zero at reset and row end
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      acc_r <= 32'd0;
    end else if (ctl.step_en && (ctl.step == q4dp_pkg::ST_ACC)) begin
      acc_r <= add_y;
    end
  end

  assign sum = acc_r;

endmodule

`default_nettype wire

// ===== hdl/q4dp_merge.sv =====
// ----------------------------------------------------------------------------
// q4dp_merge
// Combine the four lane sums: pairwise adds registered, then the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module q4dp_merge (
  input  wire logic             clk,
  input  wire logic             start,
  input  wire logic [3:0][31:0] lane_sum,
  output logic      [31:0]      total
);

  logic [31:0] a_r, b_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= q4dp_pkg::f32_add(lane_sum[0], lane_sum[1]);
      b_r <= q4dp_pkg::f32_add(lane_sum[2], lane_sum[3]);
    end
  end

  assign total = q4dp_pkg::f32_add(a_r, b_r);

endmodule

`default_nettype wire

// ===== hdl/q4_block_dot_product.sv =====
// ----------------------------------------------------------------------------
// q4_block_dot_product
// Q4 weight block dot product against a banked single-precision vector store,
// four summation lanes and a merging stage.
// ----------------------------------------------------------------------------
//
//   port    dir   beat carries
//   in_ch   sink  load (index, value) or weight block (scale, 16 bytes, row end)
//   out_ch  src   row sum (IEEE single) and column overflow flag
//
// A load beat writes its bank when accepted. A weight block is accepted, then
// the four store banks are read, eight words each (one word per bank per
// cycle), then nine add/multiply steps run on each lane's shared units. A block
// past the store only sets the overflow flag. Row end runs the merge after it.
// Reset clears control state and lane sums; the store is not cleared.
// The result register holds a row sum while the next row proceeds; the block
// stalls at row end only while the previous result is not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none

module q4_block_dot_product (
  input  wire logic   clk,
  input  wire logic   rst_n,
  q4dp_in_if.sink     in_ch,
  q4dp_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_SUM1 = 3'd3;
  localparam logic [2:0] S_SUM2 = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [q4dp_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          rd_vld_r;
  logic [2:0]                    rd_j_r;
  logic                          last_r;
  logic [127:0]                  q_r;
  logic [31:0]                   scale_r;
  logic                          out_vld_r;
  logic [31:0]                   out_sum_r;
  logic                          out_ovf_r;

  logic                          accept, is_load, is_block, blk_past, load_ok;
  logic                          rd_en, sum_fire, merge_start;
  logic [q4dp_pkg::POS_W+2:0]    rd_full;
  logic [q4dp_pkg::BANK_AW-1:0]  rd_addr, wr_addr;
  logic [3:0][31:0]              lane_sum;
  logic [31:0]                   total;
  q4dp_pkg::lane_ctl_t           ctl;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_load     = accept && (in_ch.operation == q4dp_pkg::OP_LOAD);
  assign is_block    = accept && (in_ch.operation == q4dp_pkg::OP_BLOCK);
  assign blk_past    = (pos_r >= q4dp_pkg::POS_W'(q4dp_pkg::NBLK));
  assign load_ok     = is_load && ({18'd0, in_ch.act_index} < 32'(q4dp_pkg::VECTOR_DEPTH));

  // result register frees at S_SUM2 when empty or being drained
  assign sum_fire    = (state_r == S_SUM2) && (!out_vld_r || out_ch.ready);
  assign merge_start = (state_r == S_SUM1);

  // bank word address of activation 32*pos + 16h + 4g + lane is 8*pos + j
  assign rd_en   = (state_r == S_READ);
  assign rd_full = {pos_r, cnt_r[2:0]};
  assign rd_addr = rd_full[q4dp_pkg::BANK_AW-1:0];
  assign wr_addr = q4dp_pkg::BANK_AW'(in_ch.act_index >> 2);

  always_comb begin
    ctl.clr      = sum_fire;
    ctl.prod_en  = rd_vld_r;
    ctl.prod_idx = rd_j_r;
    ctl.step_en  = (state_r == S_CALC);
    ctl.step     = cnt_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_block) begin
          if (blk_past) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_ch.row_end ? S_SUM1 : S_IDLE;
          end else begin
            cnt_nxt   = 4'd0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (cnt_r == 4'd7) begin
          cnt_nxt   = 4'd0;
          state_nxt = S_CALC;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_CALC: begin
        if (cnt_r == q4dp_pkg::ST_ACC) begin
          cnt_nxt   = 4'd0;
          pos_nxt   = pos_r + q4dp_pkg::POS_W'(1);
          state_nxt = last_r ? S_SUM1 : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_SUM1: state_nxt = S_SUM2;
      S_SUM2: begin
        if (sum_fire) begin
          pos_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= 4'd0;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      ovf_r    <= ovf_nxt;
      rd_vld_r <= rd_en;
      if (sum_fire) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  // hold block payload and result payload
  always_ff @(posedge clk) begin
    rd_j_r <= cnt_r[2:0];
    if (is_block) begin
      q_r     <= {in_ch.quant_bytes_hi, in_ch.quant_bytes_lo};
      scale_r <= q4dp_pkg::half_to_f32(in_ch.block_scale);
      last_r  <= in_ch.row_end;
    end
    if (sum_fire) begin
      out_sum_r <= total;
      out_ovf_r <= ovf_r;
    end
  end

  // store banks and lanes: lane i sees bank i and bytes i, 4+i, 8+i, 12+i
  for (genvar i = 0; i < q4dp_pkg::BANKS; i++) begin : g_lane
    logic [31:0] act;

    q4dp_ram #(
      .WIDTH(32),
      .DEPTH(q4dp_pkg::BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (load_ok && (in_ch.act_index[1:0] == 2'(i))),
      .waddr(wr_addr),
      .wdata(in_ch.act_value),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(act)
    );

    q4dp_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .act   (act),
      .wbytes({q_r[8*(12+i) +: 8], q_r[8*(8+i) +: 8], q_r[8*(4+i) +: 8], q_r[8*i +: 8]}),
      .scale (scale_r),
      .sum   (lane_sum[i])
    );
  end

  q4dp_merge u_merge (
    .clk     (clk),
    .start   (merge_start),
    .lane_sum(lane_sum),
    .total   (total)
  );

  assign out_ch.valid           = out_vld_r;
  assign out_ch.row_sum         = out_sum_r;
  assign out_ch.column_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for q4_block_dot_product. Fills the activation store,
// runs a short table of directed beats (scale extremes, NaN scales, loads
// inside a row), a row that runs past the store, then random rows mixed with
// random loads. Every accepted beat goes through a bit-exact IEEE single
// predictor; each row result is compared against the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_BEATS  = 1750;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 64;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  typedef struct {
    bit        op;
    bit [13:0] idx;
    bit [31:0] val;
    bit [15:0] scale;
    bit [63:0] lo;
    bit [63:0] hi;
    bit        rend;
  } beat_t;

  typedef struct {
    bit [31:0] sum;
    bit        ovf;
  } row_res_t;

  // directed row: beat plus an optional hand-written expectation
  typedef struct {
    bit        op;
    bit [13:0] idx;
    bit [31:0] val;
    bit [15:0] scale;
    bit [63:0] lo;
    bit [63:0] hi;
    bit        rend;
    bit        typed;
    bit [31:0] tsum;
    bit        tovf;
  } dir_row_t;

  logic clk;
  logic rst_n;

  q4dp_in_if  in_ch();
  q4dp_out_if out_ch();

  q4_block_dot_product dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  bit [31:0] act_mem [q4dp_pkg::VECTOR_DEPTH];
  bit [31:0] lane_acc [4];
  int        blk_pos;
  bit        row_ovf;

  row_res_t  row_q[$];
  int        errors;
  int        cycles;
  bit        calm;       // no idling on either side
  bit        hold_req;   // ask the receiver for one long hold-off
  bit        hold_done;
  int        hold_cnt;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // IEEE single arithmetic, round to nearest even
  // --------------------------------------------------------------------------

  // small integer magnitude times 2^(bias-127) as single bits
  function automatic bit [31:0] int_to_f32(bit neg, int unsigned mag, int bias);
    int p;
    bit [31:0] m;
    if (mag == 0) return {neg, 31'd0};
    p = 0;
    for (int i = 0; i < 11; i++) if (mag[i]) p = i;
    m = mag << (23 - p);
    return {neg, 8'(bias + p), m[22:0]};
  endfunction

  function automatic bit [31:0] half_to_single(bit [15:0] h);
    if (h[14:10] == 5'd0) return int_to_f32(h[15], h[9:0], 103);
    if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
  endfunction

  function automatic bit [31:0] fp_add(bit [31:0] a, bit [31:0] b);
    bit an, bn, ai, bi, sg;
    bit [31:0] x, y;
    int ex, ey, d, e;
    bit [27:0] mx, my, sum;
    bit g, inc;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    ai = (a[30:23] == 8'hFF) && (a[22:0] == 0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == 0);
    if (an) return a | QUIET_BIT;
    if (bn) return b | QUIET_BIT;
    if (ai && bi && (a[31] != b[31])) return DEFAULT_NAN;
    if (ai) return a;
    if (bi) return b;
    // x holds the larger magnitude
    if (a[30:0] < b[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    ex = (x[30:23] == 0) ? 1 : x[30:23];
    ey = (y[30:23] == 0) ? 1 : y[30:23];
    mx = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
    my = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
    d = ex - ey;
    if (d >= 27) my = (my != 0) ? 28'd1 : 28'd0;
    else if (d > 0) my = (my >> d) | ((my & ((28'd1 << d) - 1)) != 0);
    sum = (x[31] == y[31]) ? mx + my : mx - my;
    if (sum == 0) return {a[31] & b[31], 31'd0};
    sg = x[31];
    e = ex;
    if (sum[27]) begin
      sum = (sum >> 1) | (sum & 28'd1);
      e++;
    end else begin
      while (!sum[26] && e > 1) begin
        sum = sum << 1;
        e--;
      end
    end
    g = sum[2];
    inc = g & (sum[1] | sum[0] | sum[3]);
    if (e >= 255) return {sg, 8'hFF, 23'd0};
    return {sg, sum[26] ? 8'(e) : 8'd0, sum[25:3]} + {31'd0, inc};
  endfunction

  function automatic bit [31:0] fp_mul(bit [31:0] a, bit [31:0] b);
    bit an, bn, ai, bi, az, bz, sg, lost, inc;
    int ea, eb, e, lz, sh;
    bit [47:0] pr;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    ai = (a[30:23] == 8'hFF) && (a[22:0] == 0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == 0);
    az = (a[30:0] == 0);
    bz = (b[30:0] == 0);
    sg = a[31] ^ b[31];
    if (an) return a | QUIET_BIT;
    if (bn) return b | QUIET_BIT;
    if ((ai && bz) || (bi && az)) return DEFAULT_NAN;
    if (ai || bi) return {sg, 8'hFF, 23'd0};
    if (az || bz) return {sg, 31'd0};
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    pr = 48'({a[30:23] != 0, a[22:0]}) * 48'({b[30:23] != 0, b[22:0]});
    e = ea + eb - 126;
    lz = 0;
    for (int i = 0; i < 48; i++) if (pr[i]) lz = 47 - i;
    lost = 1'b0;
    if (e - lz >= 1) begin
      pr = pr << lz;
      e = e - lz;
    end else if (e >= 1) begin
      pr = pr << (e - 1);
      e = 1;
    end else begin
      // subnormal result: shift right, keep the dropped bits as sticky
      sh = (1 - e > 48) ? 48 : 1 - e;
      lost = |(pr & ((48'd1 << sh) - 48'd1));
      pr = pr >> sh;
      e = 1;
    end
    inc = pr[23] & ((|pr[22:0]) | lost | pr[24]);
    if (e >= 255) return {sg, 8'hFF, 23'd0};
    return {sg, pr[47] ? 8'(e) : 8'd0, pr[46:24]} + {31'd0, inc};
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: advance the shadow state by one beat
  // --------------------------------------------------------------------------
  task automatic predict_beat(input beat_t bt, output bit got, output row_res_t res);
    bit [31:0] scl, p[4], part[2];
    bit [7:0]  qb;
    bit [3:0]  nib;
    int        k, base;
    got = 1'b0;
    res = '{32'd0, 1'b0};
    if (bt.op == q4dp_pkg::OP_LOAD) begin
      act_mem[bt.idx] = bt.val;
      return;
    end
    if (blk_pos * 32 + 32 > q4dp_pkg::VECTOR_DEPTH) begin
      row_ovf = 1'b1;
    end else begin
      base = blk_pos * 32;
      scl = half_to_single(bt.scale);
      for (int i = 0; i < 4; i++) begin
        for (int h = 0; h < 2; h++) begin
          for (int g = 0; g < 4; g++) begin
            k = 4 * g + i;
            qb = (k < 8) ? bt.lo[8*k +: 8] : bt.hi[8*(k-8) +: 8];
            nib = h ? qb[7:4] : qb[3:0];
            p[g] = fp_mul(int_to_f32(!nib[3], nib[3] ? nib[2:0] : 8 - nib, 127),
                          act_mem[base + 16 * h + k]);
          end
          part[h] = fp_add(fp_add(p[0], p[1]), fp_add(p[2], p[3]));
        end
        lane_acc[i] = fp_add(lane_acc[i], fp_mul(scl, fp_add(part[0], part[1])));
      end
      blk_pos++;
    end
    if (!bt.rend) return;
    got = 1'b1;
    res.sum = fp_add(fp_add(lane_acc[0], lane_acc[1]), fp_add(lane_acc[2], lane_acc[3]));
    res.ovf = row_ovf;
    lane_acc = '{default: 32'd0};
    blk_pos = 0;
    row_ovf = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sender: idle at random, present the beat, hold it until accepted
  // --------------------------------------------------------------------------
  task automatic send_beat(input beat_t bt, input bit typed, input row_res_t tres);
    bit       got;
    row_res_t res;
    while (!calm && $urandom_range(0, 99) < 35) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= bt.op;
    in_ch.act_index      <= bt.idx;
    in_ch.act_value      <= bt.val;
    in_ch.block_scale    <= bt.scale;
    in_ch.quant_bytes_lo <= bt.lo;
    in_ch.quant_bytes_hi <= bt.hi;
    in_ch.row_end        <= bt.rend;
    do @(posedge clk); while (!in_ch.ready);
    predict_beat(bt, got, res);
    if (got) row_q.push_back(typed ? tres : res);
  endtask

  function automatic bit [31:0] mid_f32();
    return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
  endfunction

  function automatic beat_t rand_beat(bit op);
    beat_t bt;
    bt.op    = op;
    bt.idx   = 14'($urandom);
    bt.val   = ($urandom_range(0, 99) < 80) ? mid_f32() : $urandom;
    bt.scale = ($urandom_range(0, 99) < 80)
             ? {1'($urandom), 5'($urandom_range(10, 18)), 10'($urandom)}
             : 16'($urandom);
    bt.lo    = {$urandom, $urandom};
    bt.hi    = {$urandom, $urandom};
    bt.rend  = ($urandom_range(0, 2) == 0);
    return bt;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  // compare each row result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (row_q.size() == 0) begin
        $display("%0t: unexpected row result sum %08h overflow %0b", $time,
                 out_ch.row_sum, out_ch.column_overflow);
        errors++;
      end else begin
        if (out_ch.row_sum !== row_q[0].sum) begin
          $display("%0t: row_sum expected %08h actual %08h", $time,
                   row_q[0].sum, out_ch.row_sum);
          errors++;
        end
        if (out_ch.column_overflow !== row_q[0].ovf) begin
          $display("%0t: column_overflow expected %0b actual %0b", $time,
                   row_q[0].ovf, out_ch.column_overflow);
          errors++;
        end
        void'(row_q.pop_front());
      end
    end
  end

  // drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tab [14];
    beat_t    bt;
    row_res_t none;
    row_res_t tres;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.act_index = '0;
    in_ch.act_value = '0;
    in_ch.block_scale = '0;
    in_ch.quant_bytes_lo = '0;
    in_ch.quant_bytes_hi = '0;
    in_ch.row_end = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    none = '{32'd0, 1'b0};
    lane_acc = '{default: 32'd0};
    blk_pos = 0;
    row_ovf = 1'b0;

    dir_tab = '{
      // extremes of the load fields
      '{q4dp_pkg::OP_LOAD,  14'd0,     32'h0000_0000, 16'h0, 64'h0, 64'h0,
        1'b0, 1'b0, 32'h0, 1'b0},
      '{q4dp_pkg::OP_LOAD,  14'd16383, 32'hFFFF_FFFF, 16'h0, 64'h0, 64'h0,
        1'b0, 1'b0, 32'h0, 1'b0},
      '{q4dp_pkg::OP_LOAD,  14'd1,     32'h3F80_0000, 16'h0, 64'h0, 64'h0,
        1'b0, 1'b0, 32'h0, 1'b0},
      // zero scale wipes the row; NaN scales propagate quieted
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h0000, '1, '1,
        1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'hFFFF, 64'h0, 64'h0,
        1'b1, 1'b1, 32'hFFFF_E000, 1'b0},
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h7E00,
        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        1'b1, 1'b1, 32'h7FC0_0000, 1'b0},
      // zero weights, then the smallest subnormal scale, then the largest half
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h3C00,
        64'h8888_8888_8888_8888, 64'h8888_8888_8888_8888,
        1'b0, 1'b0, 32'h0, 1'b0},
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h0001,
        64'hF0F0_F0F0_0F0F_0F0F, 64'h1234_5678_9ABC_DEF0,
        1'b0, 1'b0, 32'h0, 1'b0},
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h7BFF,
        64'h7777_0000_FFFF_9999, 64'hA5A5_5A5A_C3C3_3C3C,
        1'b1, 1'b0, 32'h0, 1'b0},
      // infinite scale
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h7C00, 64'h0F0F_0F0F_0F0F_0F0F, 64'h0,
        1'b1, 1'b0, 32'h0, 1'b0},
      // load within a row rewrites a word the next block reads
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'hBC00,
        64'h1111_2222_3333_4444, 64'h5555_6666_7777_AAAA,
        1'b0, 1'b0, 32'h0, 1'b0},
      '{q4dp_pkg::OP_LOAD,  14'd40, 32'hC120_0000, 16'h0, 64'h0, 64'h0,
        1'b0, 1'b0, 32'h0, 1'b0},
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h3555,
        64'hBBBB_CCCC_DDDD_EEEE, 64'h0000_1111_2222_3333,
        1'b1, 1'b0, 32'h0, 1'b0},
      // largest subnormal scale
      '{q4dp_pkg::OP_BLOCK, 14'd0, 32'h0, 16'h03FF,
        64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
        1'b1, 1'b0, 32'h0, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole store so no block ever reads an unwritten word
    for (int i = 0; i < q4dp_pkg::VECTOR_DEPTH; i++) begin
      bt = rand_beat(q4dp_pkg::OP_LOAD);
      bt.idx = 14'(i);
      bt.val = mid_f32();
      send_beat(bt, 1'b0, none);
    end

    foreach (dir_tab[i]) begin
      bt = '{dir_tab[i].op, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].scale,
             dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].rend};
      tres = '{dir_tab[i].tsum, dir_tab[i].tovf};
      send_beat(bt, dir_tab[i].typed, tres);
    end

    // row that runs two blocks past the end of the store
    for (int n = 0; n < q4dp_pkg::VECTOR_DEPTH / 32 + 2; n++) begin
      bt = rand_beat(q4dp_pkg::OP_BLOCK);
      bt.scale = {1'($urandom), 5'($urandom_range(12, 16)), 10'($urandom)};
      bt.rend = (n == q4dp_pkg::VECTOR_DEPTH / 32 + 1);
      send_beat(bt, 1'b0, none);
    end

    // random rows with loads mixed in
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n == 400) hold_req = 1'b1;
      calm = (n >= 900 && n < 1200);
      bt = rand_beat(($urandom_range(0, 99) < 25) ? q4dp_pkg::OP_LOAD
                                                  : q4dp_pkg::OP_BLOCK);
      send_beat(bt, 1'b0, none);
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (row_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/q4dp_pkg.sv
hdl/q4dp_if.sv
hdl/q4dp_ram.sv
hdl/q4dp_lane.sv
hdl/q4dp_merge.sv
hdl/q4_block_dot_product.sv
verif/tb.sv
